@@ sv/cmmd_pkg.sv @@
// Package: shared codes, register offsets and address mapping for the memory-map decoder.
package cmmd_pkg;

  // Access codes
  localparam logic [1:0] ACT_READ      = 2'd0;
  localparam logic [1:0] ACT_WRITE     = 2'd1;
  localparam logic [1:0] ACT_ABS_READ  = 2'd2;
  localparam logic [1:0] ACT_ABS_WRITE = 2'd3;

  // Route codes
  typedef enum logic [2:0] {
    RT_INTERNAL = 3'd0,
    RT_CART_ROM = 3'd1,
    RT_CART_RAM = 3'd2,
    RT_BOOT     = 3'd3,
    RT_JOYPAD   = 3'd4,
    RT_DMA      = 3'd5
  } route_t;

  // I/O register offsets within 0xFF00-0xFF7F
  localparam logic [6:0] IO_JOYP     = 7'h00;
  localparam logic [6:0] IO_SB       = 7'h01;
  localparam logic [6:0] IO_SC       = 7'h02;
  localparam logic [6:0] IO_DIV      = 7'h04;
  localparam logic [6:0] IO_NR14     = 7'h14;
  localparam logic [6:0] IO_NR24     = 7'h19;
  localparam logic [6:0] IO_LCDC     = 7'h40;
  localparam logic [6:0] IO_STAT     = 7'h41;
  localparam logic [6:0] IO_DMA      = 7'h46;
  localparam logic [6:0] IO_BOOT_OFF = 7'h50;

  localparam logic [7:0] SC_START    = 8'h81;
  localparam logic [7:0] BLOCKED_BYTE = 8'hFF;
  localparam logic [1:0] MODE_DRAW   = 2'b11;

  // Region bounds
  localparam logic [15:0] OAM_BASE   = 16'hFE00;
  localparam logic [15:0] OAM_END    = 16'hFEA0;
  localparam logic [15:0] IO_BASE    = 16'hFF00;
  localparam logic [15:0] IO_END     = 16'hFF80;

  // Unified store: video RAM (0x8000-0x9FFF) then 0xC000-0xFFFF packed behind it
  localparam int unsigned MEM_DEPTH = 24576;
  localparam int unsigned MEM_AW    = 15;
  localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_DEPTH - 1);
  localparam logic [MEM_AW-1:0] HOLE_SIZE = MEM_AW'(16'h2000);

  typedef logic [MEM_AW-1:0] mem_addr_t;

  // Each internal byte has its own entry; the cartridge RAM hole is squeezed out
  function automatic mem_addr_t mem_index(input logic [15:0] a);
    mem_addr_t idx;
    idx = a[MEM_AW-1:0];
    if (a[14]) begin
      idx = a[MEM_AW-1:0] - HOLE_SIZE;
    end
    return idx;
  endfunction

endpackage

@@ sv/cmmd_ram.sv @@
// Single-port-write, single-port-read byte RAM with registered read data.
module cmmd_ram
  import cmmd_pkg::*;
(
  input  logic      clk,
  input  logic      we,
  input  mem_addr_t waddr,
  input  logic [7:0] wdata,
  input  logic      re,
  input  mem_addr_t raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/console_memory_map_decoder_top.sv @@
// Top level: decodes one bus access per transfer against the unified internal store.
//
//  Channel | Handshake         | Payload
//  --------+-------------------+----------------------------------------------
//  input   | start / busy      | in_action, in_address, in_write_data
//  result  | out_valid strobe  | out_read_data, out_route, out_blocked, pulses,
//          |                   | out_serial_valid, out_serial_byte
//
//  One access per cycle while busy is low; each result appears on the cycle after
//  its transfer, as the read data of the store RAM is registered.
//  After reset busy stays high while the clearing pass zeroes
//  every entry of the store, one per cycle.
//  The receiver cannot stall: each result is shown for exactly one cycle.
//  The LCD enable bit, the PPU mode bits and the boot-off byte are shadowed in
//  flip-flops for gating; SB is shadowed for the serial byte.
module console_memory_map_decoder_top
  import cmmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  output logic [7:0]  out_read_data,
  output logic [2:0]  out_route,
  output logic        out_blocked,
  output logic        out_divider_reset,
  output logic        out_channel_one_trigger,
  output logic        out_channel_two_trigger,
  output logic        out_serial_valid,
  output logic [7:0]  out_serial_byte
);

  // Clearing pass and shadows
  logic       clearing_r;
  mem_addr_t  clr_cnt_r;
  logic       lcd_on_r;
  logic [1:0] ppu_mode_r;
  logic [7:0] sb_r, boot_off_r;

  // Result registers
  logic       out_valid_r;
  logic       use_mem_r;
  logic       force_bit7_r;
  logic [7:0] rd_fixed_r;
  route_t     route_r;
  logic       blocked_r, divr_r, trig1_r, trig2_r, sv_r;
  logic [7:0] sb_out_r;

  // Decode signals
  logic       acc, is_abs, is_wr;
  logic       is_vram, is_oam, is_io, cart_rom, cart_ram, low_page, lcd_on, oam_ok;
  logic [6:0] io;
  route_t     route_nxt;
  logic       blk_nxt, divr_nxt, t1_nxt, t2_nxt, sv_nxt, use_mem_nxt, bit7_nxt;
  logic [7:0] rd_fixed_nxt, sb_nxt, wval;
  logic       acc_we, mem_re;

  // RAM port
  logic       ram_we;
  mem_addr_t  ram_waddr;
  logic [7:0] ram_wdata, ram_q;

  assign busy   = clearing_r;
  assign acc    = start && !busy;
  assign is_abs = (in_action == ACT_ABS_READ) || (in_action == ACT_ABS_WRITE);
  assign is_wr  = (in_action == ACT_WRITE) || (in_action == ACT_ABS_WRITE);

  // Region decode
  assign io       = in_address[6:0];
  assign cart_rom = !in_address[15];
  assign cart_ram = (in_address[15:13] == 3'b101);
  assign is_vram  = (in_address[15:13] == 3'b100);
  assign is_oam   = (in_address >= OAM_BASE) && (in_address < OAM_END);
  assign is_io    = (in_address >= IO_BASE) && (in_address < IO_END);
  assign low_page = (in_address[15:8] == 8'h00);
  assign lcd_on   = lcd_on_r;
  assign oam_ok   = !lcd_on || !ppu_mode_r[1];

  // Access decode and side effects
  always_comb begin
    route_nxt    = RT_INTERNAL;
    blk_nxt      = 1'b0;
    divr_nxt     = 1'b0;
    t1_nxt       = 1'b0;
    t2_nxt       = 1'b0;
    sv_nxt       = 1'b0;
    sb_nxt       = 8'h00;
    use_mem_nxt  = 1'b0;
    bit7_nxt     = 1'b0;
    rd_fixed_nxt = 8'h00;
    acc_we       = 1'b0;
    mem_re       = 1'b0;
    wval         = in_write_data;
    if (!is_wr) begin
      if (!is_abs && is_io && io == IO_JOYP) begin
        route_nxt = RT_JOYPAD;
      end else if (boot_off_r == 8'h00 && low_page) begin
        route_nxt = RT_BOOT;
      end else if (cart_rom) begin
        route_nxt = RT_CART_ROM;
      end else if (cart_ram) begin
        route_nxt = RT_CART_RAM;
      end else if (!is_abs && is_oam && !oam_ok) begin
        rd_fixed_nxt = BLOCKED_BYTE;
        blk_nxt      = 1'b1;
      end else begin
        use_mem_nxt = 1'b1;
        mem_re      = acc;
        bit7_nxt    = !is_abs && is_io && io == IO_STAT;
      end
    end else if (cart_rom) begin
      route_nxt = RT_CART_ROM;
    end else if (cart_ram) begin
      route_nxt = RT_CART_RAM;
    end else if (is_abs) begin
      acc_we = acc;
    end else if (is_vram && lcd_on && ppu_mode_r == MODE_DRAW) begin
      blk_nxt = 1'b1;
    end else if (is_oam && !oam_ok) begin
      blk_nxt = 1'b1;
    end else if (is_io && io == IO_JOYP) begin
      route_nxt = RT_JOYPAD;
    end else if (is_io && io == IO_DMA) begin
      route_nxt = RT_DMA;
    end else begin
      acc_we = acc;
      if (is_io) begin
        if (io == IO_DIV) begin
          wval     = 8'h00;
          divr_nxt = 1'b1;
        end else if (io == IO_NR14 && in_write_data[7]) begin
          t1_nxt = 1'b1;
        end else if (io == IO_NR24 && in_write_data[7]) begin
          t2_nxt = 1'b1;
        end
        if (io == IO_SC && in_write_data == SC_START) begin
          sv_nxt = 1'b1;
          sb_nxt = sb_r;
        end
      end
    end
  end

  // Write port shared between clearing pass and accesses
  assign ram_we    = clearing_r || acc_we;
  assign ram_waddr = clearing_r ? clr_cnt_r : mem_index(in_address);
  assign ram_wdata = clearing_r ? 8'h00 : wval;

  cmmd_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (mem_re),
    .raddr (mem_index(in_address)),
    .rdata (ram_q)
  );

  // Clearing pass and register shadows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
      lcd_on_r   <= 1'b0;
      ppu_mode_r <= 2'b00;
      sb_r       <= 8'h00;
      boot_off_r <= 8'h00;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_LAST) begin
          clearing_r <= 1'b0;
        end
      end
      if (acc_we && is_io) begin
        case (io)
          IO_LCDC:     lcd_on_r   <= wval[7];
          IO_STAT:     ppu_mode_r <= wval[1:0];
          IO_SB:       sb_r       <= wval;
          IO_BOOT_OFF: boot_off_r <= wval;
          default:     ;
        endcase
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
    end
  end

  // Result payload, captured on each transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      use_mem_r    <= use_mem_nxt;
      force_bit7_r <= bit7_nxt;
      rd_fixed_r   <= rd_fixed_nxt;
      route_r      <= route_nxt;
      blocked_r    <= blk_nxt;
      divr_r       <= divr_nxt;
      trig1_r      <= t1_nxt;
      trig2_r      <= t2_nxt;
      sv_r         <= sv_nxt;
      sb_out_r     <= sb_nxt;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = use_mem_r ? (ram_q | {force_bit7_r, 7'b0}) : rd_fixed_r;
  assign out_route               = route_r;
  assign out_blocked             = blocked_r;
  assign out_divider_reset       = divr_r;
  assign out_channel_one_trigger = trig1_r;
  assign out_channel_two_trigger = trig2_r;
  assign out_serial_valid        = sv_r;
  assign out_serial_byte         = sb_out_r;

  // Checks
  a_valid_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy))
    else $error("result without a preceding transfer");

  a_blocked_internal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_blocked) |-> (out_route == RT_INTERNAL))
    else $error("blocked access carries an external route");

  a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> ($past(clr_cnt_r) == MEM_LAST))
    else $error("clearing pass ended early");

endmodule
